// ----- design/at_modem_line_classifier_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the AT modem line classifier
// Clocked implication checks, reset disables them.
// ----------------------------------------------------------------------------
`ifndef AT_MODEM_LINE_CLASSIFIER_UNIT_ASSERT_SVH
`define AT_MODEM_LINE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define AMLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amlc: same-cycle check failed");

// next-cycle implication
`define AMLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amlc: next-cycle check failed");

`endif

// ----- design/amlc_pkg.sv -----
// ----------------------------------------------------------------------------
// amlc_pkg
// Types, codes and prefix tables shared by the line classifier modules.
// ----------------------------------------------------------------------------
package amlc_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] text_byte;
  } amlc_item_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [1:0] call_state;
    logic       is_call_list;
  } amlc_result_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] EV_NONE = 4'd0;

  localparam logic [1:0] CS_UNKNOWN   = 2'd0;
  localparam logic [1:0] CS_CONNECTED = 2'd1;
  localparam logic [1:0] CS_DIALING   = 2'd2;
  localparam logic [1:0] CS_RINGING   = 2'd3;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_FOUR  = 8'h34;

  localparam int         NUM_PREFIXES   = 12;
  localparam int         CALL_LIST_SLOT = 7;
  localparam logic [3:0] LEN_SAT        = 4'd13;
  localparam logic [1:0] COMMA_MAX      = 2'd3;

  localparam logic [95:0] PREFIX_TEXT [NUM_PREFIXES] = '{
    96'("OK"), 96'("RING"), 96'("NO CARRIER"), 96'("ERROR"),
    96'("NO DIAL TONE"), 96'("BUSY"), 96'("NO ANSWER"), 96'("+CLCC:"),
    96'("ATD"), 96'("ATH"), 96'("ATA"), 96'("AT+CLCC")
  };

  localparam logic [3:0] PREFIX_LEN [NUM_PREFIXES] = '{
    4'd2, 4'd4, 4'd10, 4'd5, 4'd12, 4'd4, 4'd9, 4'd6, 4'd3, 4'd3, 4'd3, 4'd7
  };

  localparam logic [3:0] PREFIX_EVENT [NUM_PREFIXES] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd0, 4'd8, 4'd9, 4'd10, 4'd11
  };

  // character at position pos of prefix idx; zero past its end
  function automatic logic [7:0] prefix_char(input logic [3:0] idx,
                                             input logic [3:0] pos);
    int           sh;
    logic [95:0]  txt;
    sh  = (int'(PREFIX_LEN[idx]) - 1 - int'(pos)) * 8;
    txt = PREFIX_TEXT[idx];
    if (sh < 0) begin
      return 8'd0;
    end
    txt = txt >> sh;
    return txt[7:0];
  endfunction

endpackage

// ----- design/amlc_line_track.sv -----
// ----------------------------------------------------------------------------
// amlc_line_track
// Per-line state: prefix match bits, length, comma count and status byte.
// Classifies the line when it closes and returns the state to its start.
// ----------------------------------------------------------------------------
module amlc_line_track (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  amlc_pkg::amlc_item_t   item,
  output logic                   emit,
  output amlc_pkg::amlc_result_t res
);

  logic [3:0]  line_length;
  logic [11:0] prefix_alive;
  logic [1:0]  comma_count;
  logic [7:0]  previous_char;
  logic [7:0]  status_char;

  logic [3:0]  line_length_next;
  logic [11:0] prefix_alive_next;
  logic [1:0]  comma_count_next;
  logic [7:0]  previous_char_next;
  logic [7:0]  status_char_next;

  logic        close;
  logic [7:0]  c;
  logic [3:0]  ev;
  logic        cl;
  logic [1:0]  st;

  assign c     = item.text_byte;
  assign close = (item.operation == amlc_pkg::OP_END) ||
                 (c == amlc_pkg::CHAR_CR) || (c == amlc_pkg::CHAR_LF);
  assign emit  = close && (line_length != 4'd0);

  always_comb begin
    ev = amlc_pkg::EV_NONE;
    cl = 1'b0;
    for (int i = amlc_pkg::NUM_PREFIXES - 1; i >= 0; i--) begin
      if (prefix_alive[i] && (line_length >= amlc_pkg::PREFIX_LEN[i])) begin
        ev = amlc_pkg::PREFIX_EVENT[i];
        cl = (i == amlc_pkg::CALL_LIST_SLOT);
      end
    end
    st = amlc_pkg::CS_UNKNOWN;
    if (cl && (comma_count == amlc_pkg::COMMA_MAX)) begin
      unique case (status_char)
        amlc_pkg::CHAR_ZERO: st = amlc_pkg::CS_CONNECTED;
        amlc_pkg::CHAR_TWO:  st = amlc_pkg::CS_DIALING;
        amlc_pkg::CHAR_FOUR: st = amlc_pkg::CS_RINGING;
        default:             st = amlc_pkg::CS_UNKNOWN;
      endcase
    end
    res.event_code   = ev;
    res.call_state   = st;
    res.is_call_list = cl;
  end

  always_comb begin
    line_length_next   = line_length;
    prefix_alive_next  = prefix_alive;
    comma_count_next   = comma_count;
    previous_char_next = previous_char;
    status_char_next   = status_char;
    if (close) begin
      line_length_next   = 4'd0;
      prefix_alive_next  = '1;
      comma_count_next   = 2'd0;
      previous_char_next = 8'd0;
      status_char_next   = 8'd0;
    end else begin
      for (int i = 0; i < amlc_pkg::NUM_PREFIXES; i++) begin
        if ((line_length < amlc_pkg::PREFIX_LEN[i]) &&
            (amlc_pkg::prefix_char(4'(i), line_length) != c)) begin
          prefix_alive_next[i] = 1'b0;
        end
      end
      if ((comma_count != amlc_pkg::COMMA_MAX) && (c == amlc_pkg::CHAR_COMMA)) begin
        comma_count_next = comma_count + 2'd1;
        if (comma_count_next == amlc_pkg::COMMA_MAX) begin
          status_char_next = previous_char;
        end
      end
      previous_char_next = c;
      if (line_length != amlc_pkg::LEN_SAT) begin
        line_length_next = line_length + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= 4'd0;
      prefix_alive  <= '1;
      comma_count   <= 2'd0;
      previous_char <= 8'd0;
      status_char   <= 8'd0;
    end else if (advance) begin
      line_length   <= line_length_next;
      prefix_alive  <= prefix_alive_next;
      comma_count   <= comma_count_next;
      previous_char <= previous_char_next;
      status_char   <= status_char_next;
    end
  end

endmodule

// ----- design/amlc_result_reg.sv -----
// ----------------------------------------------------------------------------
// amlc_result_reg
// Output register: holds a result beat until the far side takes it.
// ----------------------------------------------------------------------------
module amlc_result_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   emit,
  input  amlc_pkg::amlc_result_t res,
  input  logic                   result_stall,
  output logic                   ready,
  output logic                   result_valid,
  output amlc_pkg::amlc_result_t result
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && advance && emit) begin
      result <= res;
    end
  end

endmodule

// ----- design/at_modem_line_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// at_modem_line_classifier_unit: AT modem line classifier
// One byte beat per cycle; a line-end beat goes to the input register, then
// its result to the result register. Input stalls only while a result beat
// waits stalled. Classify logic lies between input and result register.
// Synchronous reset empties both registers and restarts the line state.
// ----------------------------------------------------------------------------
`include "at_modem_line_classifier_unit_assert.svh"

module at_modem_line_classifier_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  amlc_pkg::amlc_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output amlc_pkg::amlc_result_t result
);

  logic                   item_q_valid;
  amlc_pkg::amlc_item_t   item_q;
  logic                   res_ready;
  logic                   advance;
  logic                   emit;
  amlc_pkg::amlc_result_t res;

  assign advance    = item_q_valid && res_ready;
  assign item_stall = item_q_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  amlc_line_track u_line_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .emit    (emit),
    .res     (res)
  );

  amlc_result_reg u_result_reg (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .emit         (emit),
    .res          (res),
    .result_stall (result_stall),
    .ready        (res_ready),
    .result_valid (result_valid),
    .result       (result)
  );

  `AMLC_ASSERT_NOW(a_stall_only_when_blocked, clk, rst, item_stall, result_valid && result_stall)
  `AMLC_ASSERT_NOW(a_call_list_no_event, clk, rst, result_valid && result.is_call_list, result.event_code == amlc_pkg::EV_NONE)
  `AMLC_ASSERT_NOW(a_state_needs_call_list, clk, rst, result_valid && (result.call_state != amlc_pkg::CS_UNKNOWN), result.is_call_list)
  `AMLC_ASSERT_NEXT(a_emit_reaches_output, clk, rst, advance && emit, result_valid)

endmodule
